### sv/ffc_pkg.sv
// ============================================================================
// ffc_pkg - shared definitions for the four-function calculator core
// Key codes, operator codes and the request type of the mul/div unit.
// ============================================================================
`default_nettype none

package ffc_pkg;

    localparam int DATA_W_DEF = 64;   // default arithmetic width
    localparam int DISP_W     = 64;   // display bus width (fixed)
    localparam int FUNC_W     = 3;
    localparam int DIGIT_W    = 4;

    // key codes; add..div double as the pending operator code
    localparam logic [FUNC_W-1:0] KEY_DIGIT  = 3'd0;
    localparam logic [FUNC_W-1:0] KEY_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] KEY_SUB    = 3'd2;
    localparam logic [FUNC_W-1:0] KEY_MUL    = 3'd3;
    localparam logic [FUNC_W-1:0] KEY_DIV    = 3'd4;
    localparam logic [FUNC_W-1:0] KEY_EQUALS = 3'd5;
    localparam logic [FUNC_W-1:0] KEY_CLEAR  = 3'd6;
    localparam logic [FUNC_W-1:0] KEY_BACK   = 3'd7;

    localparam logic [FUNC_W-1:0] OP_NONE    = 3'd0;

    localparam int TEN = 10;

    typedef enum logic [1:0] {
        UOP_MUL = 2'b01,
        UOP_DIV = 2'b10
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

endpackage

`default_nettype wire

### sv/ffc_if.sv
// ============================================================================
// ffc_if - channel interfaces of the calculator core
// Key channel (func, digit) and display channel (display_value, showing_entry).
// ============================================================================
`default_nettype none

interface ffc_key_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [3:0] digit;

    modport source (output valid, output func, output digit, input ready);
    modport sink   (input valid, input func, input digit, output ready);
endinterface

interface ffc_disp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] display_value;
    logic               showing_entry;

    modport source (output valid, output display_value, output showing_entry, input ready);
    modport sink   (input valid, input display_value, input showing_entry, output ready);
endinterface

`default_nettype wire

### sv/four_function_calculator_core_top.sv
// ============================================================================
// four_function_calculator_core_top - integer keypad calculator engine
// One key per transaction; one display transaction back for every key.
// ============================================================================
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------------
//  key     | in  | valid / ready  | func[2:0], digit[3:0]
//  disp    | out | valid / ready  | display_value[63:0], showing_entry
//
//  Digit and clear keys, and operator or equals keys that add, subtract
//  or only load, go from acceptance through ST_FIN to the result register.
//  Multiply, divide and backspace first run through the shared bit-serial
//  mul/div unit, one quotient/product bit a cycle.
//  Reset clears accumulator, entry, pending operator and all handshakes.
//  key.ready is high only while idle. A finished result waits in the
//  sequencer until the display register is free, so a stalled display
//  holds back at most one further key.
// ============================================================================
`default_nettype none

module four_function_calculator_core_top #(
    parameter int DATA_WIDTH = ffc_pkg::DATA_W_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    ffc_key_if.sink      key,
    ffc_disp_if.source   disp
);
    import ffc_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,   // waiting on the mul/div unit
        ST_FIN  = 3'b100    // state updated, result to be posted
    } state_t;

    state_t               state_reg, state_next;
    logic [W-1:0]         acc_reg,   acc_next;
    logic [W-1:0]         entry_reg, entry_next;
    logic [FUNC_W-1:0]    pend_reg,  pend_next;
    logic                 pres_reg,  pres_next;
    logic                 tgt_entry_reg, tgt_entry_next; // unit result goes to entry
    logic                 out_valid_reg, out_valid_next;
    logic signed [DISP_W-1:0] disp_reg, disp_next;
    logic                 show_reg,  show_next;

    unit_req_t            ureq;
    logic [W-1:0]         ua;
    logic [W-1:0]         ub;
    logic                 udone;
    logic [W-1:0]         ures;

    logic                 need_comb;
    logic [W-1:0]         opnd;
    logic signed [W-1:0]  shown;

    ffc_muldiv #(.W(W)) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ureq),
        .a      (ua),
        .b      (ub),
        .done   (udone),
        .result (ures)
    );

    assign key.ready = (state_reg == ST_IDLE);
    assign shown     = pres_reg ? entry_reg : acc_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        entry_next     = entry_reg;
        pend_next      = pend_reg;
        pres_next      = pres_reg;
        tgt_entry_next = tgt_entry_reg;
        out_valid_next = out_valid_reg && !disp.ready;
        disp_next      = disp_reg;
        show_next      = show_reg;
        ureq.start     = 1'b0;
        ureq.op        = UOP_MUL;
        ua             = acc_reg;
        ub             = entry_reg;
        need_comb      = 1'b0;
        opnd           = entry_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (key.valid)
                begin
                    state_next = ST_FIN;
                    unique case (key.func)
                        KEY_DIGIT:
                        begin
                            // entry * 10 + digit as two shifted adds
                            entry_next = {entry_reg[W-4:0], 3'b000}
                                       + {entry_reg[W-2:0], 1'b0}
                                       + W'(key.digit);
                            pres_next  = 1'b1;
                        end
                        KEY_CLEAR:
                        begin
                            acc_next   = '0;
                            entry_next = '0;
                            pend_next  = OP_NONE;
                            pres_next  = 1'b0;
                        end
                        KEY_EQUALS:
                        begin
                            if (pend_reg != OP_NONE)
                            begin
                                need_comb = 1'b1;
                                opnd      = pres_reg ? entry_reg : acc_reg;
                            end
                            else if (pres_reg)
                                acc_next = entry_reg;
                            pend_next  = OP_NONE;
                            entry_next = '0;
                            pres_next  = 1'b0;
                        end
                        KEY_BACK:
                        begin
                            ureq.start     = 1'b1;
                            ureq.op        = UOP_DIV;
                            ua             = entry_reg;
                            ub             = W'(TEN);
                            tgt_entry_next = 1'b1;
                            state_next     = ST_BUSY;
                        end
                        default:
                        begin
                            // operator keys
                            if (pend_reg != OP_NONE && pres_reg)
                                need_comb = 1'b1;
                            else if (pres_reg)
                                acc_next = entry_reg;
                            pend_next  = key.func;
                            entry_next = '0;
                            pres_next  = 1'b0;
                        end
                    endcase

                    if (need_comb)
                    begin
                        case (pend_reg)
                            KEY_ADD: acc_next = acc_reg + opnd;
                            KEY_SUB: acc_next = acc_reg - opnd;
                            KEY_MUL:
                            begin
                                ureq.start     = 1'b1;
                                ureq.op        = UOP_MUL;
                                ub             = opnd;
                                tgt_entry_next = 1'b0;
                                state_next     = ST_BUSY;
                            end
                            default:
                            begin
                                ureq.start     = 1'b1;
                                ureq.op        = UOP_DIV;
                                ub             = opnd;
                                tgt_entry_next = 1'b0;
                                state_next     = ST_BUSY;
                            end
                        endcase
                    end
                end
            end
            ST_BUSY:
            begin
                if (udone)
                begin
                    if (tgt_entry_reg)
                    begin
                        entry_next = ures;
                        if (ures == '0)
                            pres_next = 1'b0;
                    end
                    else
                        acc_next = ures;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || disp.ready)
                begin
                    out_valid_next = 1'b1;
                    disp_next      = DISP_W'(shown);   // sign-extends
                    show_next      = pres_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            entry_reg     <= '0;
            pend_reg      <= OP_NONE;
            pres_reg      <= 1'b0;
            tgt_entry_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            entry_reg     <= entry_next;
            pend_reg      <= pend_next;
            pres_reg      <= pres_next;
            tgt_entry_reg <= tgt_entry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        disp_reg <= disp_next;
        show_reg <= show_next;
    end

    assign disp.valid         = out_valid_reg;
    assign disp.display_value = disp_reg;
    assign disp.showing_entry = show_reg;

endmodule

`default_nettype wire

### sv/ffc_muldiv.sv
// ============================================================================
// ffc_muldiv - iterative multiply / signed divide unit
// One bit per cycle: shift-add multiply (low word) or restoring divide on
// magnitudes with sign fix-up. Zero divisor gives 0.
// ============================================================================
`default_nettype none

module ffc_muldiv #(
    parameter int W = ffc_pkg::DATA_W_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ffc_pkg::unit_req_t req,
    input  wire logic [W-1:0]      a,
    input  wire logic [W-1:0]      b,
    output logic                   done,
    output logic [W-1:0]           result
);
    import ffc_pkg::*;

    localparam int CW = $clog2(W);

    logic           run_reg,  run_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg,  cnt_next;
    unit_op_t       op_reg,   op_next;
    logic           neg_reg,  neg_next;
    logic           zero_reg, zero_next;
    logic [W-1:0]   x_reg,    x_next;   // multiplicand / divisor magnitude
    logic [W-1:0]   y_reg,    y_next;   // multiplier / dividend -> quotient
    logic [W-1:0]   acc_reg,  acc_next; // product / remainder

    logic [W:0]     rem_sh;
    logic [W:0]     diff;
    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;

    assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
    assign rem_sh = {acc_reg, y_reg[W-1]};
    assign diff   = rem_sh - {1'b0, x_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            op_next  = req.op;
            acc_next = '0;
            if (req.op == UOP_MUL)
            begin
                x_next = a;
                y_next = b;
            end
            else
            begin
                x_next = mag_b;
                y_next = mag_a;
            end
            neg_next  = a[W-1] ^ b[W-1];
            zero_next = (b == '0);
        end
        else if (run_reg)
        begin
            if (op_reg == UOP_MUL)
            begin
                if (y_reg[0])
                    acc_next = acc_reg + x_reg;
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            else
            begin
                if (!diff[W])
                begin
                    acc_next = diff[W-1:0];
                    y_next   = {y_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[W-1:0];
                    y_next   = {y_reg[W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= UOP_MUL;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        if (op_reg == UOP_MUL)
            result = acc_reg;
        else if (zero_reg)
            result = '0;
        else if (neg_reg)
            result = ~y_reg + 1'b1;
        else
            result = y_reg;
    end

    assign done = done_reg;

endmodule

`default_nettype wire
